// ----- hw/rtl/rrhr_pkg.sv -----
// ----------------------------------------------------------------------------
// rrhr_pkg: shared types and constants of the RRIP reuse replacement engine
// Holds the request and result item layouts, the per-block state layout and
// the operation codes of the shared way unit.
// ----------------------------------------------------------------------------
package rrhr_pkg;

  localparam int IN_SET_W  = 11;
  localparam int IN_WAY_W  = 4;
  localparam int MASK_WAYS = 16;

  localparam logic [1:0]  RRPV_MAX         = 2'd3;
  localparam logic [1:0]  CTR_MAX          = 2'd3;
  localparam logic [1:0]  CTR_FILL         = 2'd1;
  localparam logic [1:0]  DEPTH_DEFAULT    = 2'd2;
  localparam logic [15:0] DECAY_PERIOD_RST = 16'd2048;

  typedef enum logic {
    REQ_VICTIM = 1'b0,
    REQ_UPDATE = 1'b1
  } req_kind_e;

  typedef enum logic [1:0] {
    OP_MAX  = 2'd0,
    OP_AGE  = 2'd1,
    OP_HIT  = 2'd2,
    OP_FILL = 2'd3
  } way_op_e;

  typedef struct packed {
    logic                req_type;
    logic [IN_SET_W-1:0] set_index;
    logic [IN_WAY_W-1:0] way_index;
    logic                hit;
    logic [15:0]         valid_mask;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] written_depth;
  } rsp_t;

  typedef struct packed {
    logic [1:0] rrpv;
    logic [1:0] reuse;
    logic [1:0] dead;
  } blk_t;

  localparam blk_t BLK_RST = '{rrpv: 2'd3, reuse: 2'd1, dead: 2'd1};

  function automatic logic [1:0] sat_dec(input logic [1:0] v);
    return (v == 2'd0) ? 2'd0 : v - 2'd1;
  endfunction

endpackage

// ----- hw/rtl/rrip_reuse_hybrid_replacement.sv -----
// ----------------------------------------------------------------------------
// rrip_reuse_hybrid_replacement: RRIP replacement engine with reuse and
// dead-block counters
// Sequencer around a set-wide state RAM and one shared per-way unit.
// ----------------------------------------------------------------------------
// Usage: requests enter on the in_* valid/ready channel, one at a time, and
// each produces exactly one result item on the out_* valid/ready channel.
// A victim request returns a victim way; an update returns the depth written.
// The decay period register is written through cfg_we_i / cfg_data_i; the user
// must write it only while the block is idle, which the block does not enforce.
// Sequence: every request first reduces the set and way indexes (a
// reciprocal multiply, then the remainder) and then reads the set row. An
// update applies the hit or fill in the way unit, writes the row back and
// issues its result once the output register is free. A victim request
// scans the ways one per cycle through the shared way unit: the lowest
// invalid way ends the scan and is returned without a write-back, while a
// full set takes one pass to find the maximum and a second to age the row
// and pick the first way at the maximum, then writes the row back. An update
// that triggers the global decay first sweeps every set row, one row per cycle.
// After reset a clearing pass writes every row with its reset state; no item
// is accepted until it ends.
// Results sit in an output register; a new item is accepted while a result
// waits, and the block holds its next result until the receiver takes it.
// ----------------------------------------------------------------------------
module rrip_reuse_hybrid_replacement
  import rrhr_pkg::*;
#(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int CNT_W = $clog2(NUM_SETS + 1);
  localparam int ROW_W = NUM_WAYS * $bits(blk_t);

  // Reciprocals rounded up give exact quotients for every index the fields
  // can carry.
  localparam int SET_SH = IN_SET_W + SET_W;
  localparam int SET_RW = IN_SET_W + 2;
  localparam int WAY_SH = IN_WAY_W + WAY_W;
  localparam int WAY_RW = IN_WAY_W + 2;

  localparam logic [SET_RW-1:0]   SET_RCP =
    SET_RW'(((1 << SET_SH) + NUM_SETS - 1) / NUM_SETS);
  localparam logic [WAY_RW-1:0]   WAY_RCP =
    WAY_RW'(((1 << WAY_SH) + NUM_WAYS - 1) / NUM_WAYS);
  localparam logic [IN_SET_W-1:0] SETS_LO   = IN_SET_W'(NUM_SETS);
  localparam logic [IN_WAY_W-1:0] WAYS_LO   = IN_WAY_W'(NUM_WAYS);
  localparam logic [WAY_W-1:0]    WAY_LAST  = WAY_W'(NUM_WAYS - 1);
  localparam logic [CNT_W-1:0]    CNT_LAST  = CNT_W'(NUM_SETS - 1);
  localparam logic [CNT_W-1:0]    CNT_END   = CNT_W'(NUM_SETS);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_REDUCE = 4'd2;
  localparam logic [3:0] S_DECAY  = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_LOAD   = 4'd5;
  localparam logic [3:0] S_SCAN1  = 4'd6;
  localparam logic [3:0] S_SCAN2  = 4'd7;
  localparam logic [3:0] S_UPD    = 4'd8;
  localparam logic [3:0] S_WRITE  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;
  localparam logic [3:0] S_REMAIN = 4'd11;

  typedef blk_t [NUM_WAYS-1:0] row_t;

  // Control state
  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] ctr_q, ctr_d;
  logic [15:0]      acc_q, acc_d;
  logic [15:0]      period_q, period_d;
  logic             out_valid_q, out_valid_d;
  logic             sweep_wv_q, sweep_wv_d;
  logic             decay_q, decay_d;

  // Payload state
  req_t             req_q, req_d;
  logic [SET_W-1:0] set_q, set_d;
  logic [WAY_W-1:0] w_q, w_d;
  logic [IN_SET_W-1:0] set_quo_q, set_quo_d;
  logic [IN_WAY_W-1:0] way_quo_q, way_quo_d;
  row_t             row_q, row_d;
  logic [1:0]       top_q, top_d;
  logic [1:0]       add_q, add_d;
  logic [WAY_W-1:0] vict_q, vict_d;
  logic             found_q, found_d;
  logic [1:0]       depth_q, depth_d;
  logic [SET_W-1:0] sweep_wa_q, sweep_wa_d;
  rsp_t             out_q, out_d;

  // RAM port signals
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic             ram_re;
  logic [SET_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;

  // Way unit signals
  way_op_e          wu_op;
  blk_t             wu_blk;
  logic [1:0]       wu_top;
  logic [1:0]       wu_depth;

  row_t             row_rst;
  row_t             row_rd;
  row_t             row_dec;
  logic [NUM_WAYS-1:0] inv_vec;

  logic [IN_SET_W+SET_RW-1:0] set_prod;
  logic [IN_WAY_W+WAY_RW-1:0] way_prod;
  logic [IN_SET_W-1:0] set_rem;
  logic [IN_WAY_W-1:0] way_rem;
  logic [15:0]      acc_next;
  logic [15:0]      period_eff;
  logic             way_last;
  logic [WAY_W+3:0] vict_ext;

  rrhr_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rrhr_way_unit u_way_unit (
    .op_i   (wu_op),
    .blk_i  (row_q[w_q]),
    .top_i  (top_q),
    .add_i  (add_q),
    .blk_o  (wu_blk),
    .top_o  (wu_top),
    .depth_o(wu_depth)
  );

  // Ways past the mask width count as valid.
  for (genvar g = 0; g < NUM_WAYS; g++) begin : g_inv
    if (g < MASK_WAYS) begin : g_mask
      assign inv_vec[g] = ~req_q.valid_mask[g];
    end else begin : g_nomask
      assign inv_vec[g] = 1'b0;
    end
  end

  always_comb begin
    row_rd = ram_rdata;
    for (int i = 0; i < NUM_WAYS; i++) begin
      row_rst[i]      = BLK_RST;
      row_dec[i]      = row_rd[i];
      row_dec[i].dead = sat_dec(row_rd[i].dead);
    end
  end

  // Index reduction: the quotient comes from a reciprocal multiply, and the
  // remainder is formed in the cycle after. Both remainders fit the field width,
  // so the product with the table size is only needed modulo that width.
  assign set_prod = req_q.set_index * SET_RCP;
  assign way_prod = req_q.way_index * WAY_RCP;
  assign set_rem  = req_q.set_index - set_quo_q * SETS_LO;
  assign way_rem  = req_q.way_index - way_quo_q * WAYS_LO;

  assign acc_next   = acc_q + 16'd1;
  assign period_eff = (period_q == 16'd0) ? 16'd1 : period_q;
  assign way_last   = (w_q == WAY_LAST);
  assign vict_ext   = {4'd0, vict_q};

  always_comb begin
    state_d     = state_q;
    ctr_d       = ctr_q;
    acc_d       = acc_q;
    period_d    = period_q;
    out_valid_d = out_valid_q;
    sweep_wv_d  = 1'b0;
    decay_d     = decay_q;
    req_d       = req_q;
    set_d       = set_q;
    w_d         = w_q;
    set_quo_d   = set_quo_q;
    way_quo_d   = way_quo_q;
    row_d       = row_q;
    top_d       = top_q;
    add_d       = add_q;
    vict_d      = vict_q;
    found_d     = found_q;
    depth_d     = depth_q;
    sweep_wa_d  = sweep_wa_q;
    out_d       = out_q;

    ram_we      = 1'b0;
    ram_waddr   = set_q;
    ram_wdata   = row_q;
    ram_re      = 1'b0;
    ram_raddr   = set_q;
    wu_op       = OP_MAX;

    if (cfg_we_i) begin
      period_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Write half of the decay sweep: the row read in the previous cycle.
    if (sweep_wv_q) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_wa_q;
      ram_wdata = row_dec;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ctr_q[SET_W-1:0];
        ram_wdata = row_rst;
        if (ctr_q == CNT_LAST) begin
          ctr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          set_d   = '0;
          w_d     = '0;
          decay_d = 1'b0;
          state_d = S_REDUCE;
          if (in_data_i.req_type == REQ_UPDATE) begin
            if (acc_next >= period_eff) begin
              acc_d   = 16'd0;
              decay_d = 1'b1;
            end else begin
              acc_d = acc_next;
            end
          end
        end
      end
      S_REDUCE: begin
        set_quo_d = IN_SET_W'(set_prod >> SET_SH);
        way_quo_d = IN_WAY_W'(way_prod >> WAY_SH);
        state_d   = S_REMAIN;
      end
      S_REMAIN: begin
        set_d   = SET_W'(set_rem);
        w_d     = WAY_W'(way_rem);
        ctr_d   = '0;
        state_d = decay_q ? S_DECAY : S_READ;
      end
      S_DECAY: begin
        if (ctr_q != CNT_END) begin
          ram_re     = 1'b1;
          ram_raddr  = ctr_q[SET_W-1:0];
          sweep_wv_d = 1'b1;
          sweep_wa_d = ctr_q[SET_W-1:0];
          ctr_d      = ctr_q + 1'b1;
        end else if (!sweep_wv_q) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        row_d   = row_rd;
        top_d   = 2'd0;
        found_d = 1'b0;
        vict_d  = '0;
        depth_d = 2'd0;
        if (req_q.req_type == REQ_UPDATE) begin
          state_d = S_UPD;
        end else begin
          w_d     = '0;
          state_d = S_SCAN1;
        end
      end
      S_SCAN1: begin
        wu_op = OP_MAX;
        top_d = wu_top;
        if (inv_vec[w_q]) begin
          vict_d  = w_q;
          state_d = S_DONE;
        end else if (way_last) begin
          add_d   = RRPV_MAX - wu_top;
          w_d     = '0;
          state_d = S_SCAN2;
        end else begin
          w_d = w_q + 1'b1;
        end
      end
      S_SCAN2: begin
        wu_op      = OP_AGE;
        row_d[w_q] = wu_blk;
        if (!found_q && wu_blk.rrpv == RRPV_MAX) begin
          found_d = 1'b1;
          vict_d  = w_q;
        end
        if (way_last) begin
          state_d = S_WRITE;
        end else begin
          w_d = w_q + 1'b1;
        end
      end
      S_UPD: begin
        wu_op      = req_q.hit ? OP_HIT : OP_FILL;
        row_d[w_q] = wu_blk;
        depth_d    = wu_depth;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = set_q;
        ram_wdata = row_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          if (req_q.req_type == REQ_UPDATE) begin
            out_d.victim_way    = 4'd0;
            out_d.written_depth = depth_q;
          end else begin
            out_d.victim_way    = vict_ext[3:0];
            out_d.written_depth = 2'd0;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ctr_q       <= '0;
      acc_q       <= 16'd0;
      period_q    <= DECAY_PERIOD_RST;
      out_valid_q <= 1'b0;
      sweep_wv_q  <= 1'b0;
      decay_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      acc_q       <= acc_d;
      period_q    <= period_d;
      out_valid_q <= out_valid_d;
      sweep_wv_q  <= sweep_wv_d;
      decay_q     <= decay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    set_q      <= set_d;
    w_q        <= w_d;
    set_quo_q  <= set_quo_d;
    way_quo_q  <= way_quo_d;
    row_q      <= row_d;
    top_q      <= top_d;
    add_q      <= add_d;
    vict_q     <= vict_d;
    found_q    <= found_d;
    depth_q    <= depth_d;
    sweep_wa_q <= sweep_wa_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // An idle block never touches the state RAM.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("state RAM written while idle");

  // Sweep write-backs only belong to the decay pass.
  a_sweep_in_decay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_wv_q |-> (state_q == S_DECAY))
    else $error("decay write-back outside the decay sweep");

  // Aging lifts the set maximum to exactly three.
  a_age_amount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN2) |-> (2'(top_q + add_q) == RRPV_MAX))
    else $error("aging amount does not reach the maximum value");

  // A result carries either a victim or a depth, never both.
  a_result_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.victim_way == 4'd0 || out_data_o.written_depth == 2'd0))
    else $error("result item carries both a victim and a depth");
`endif

endmodule

// ----- hw/rtl/rrhr_ram.sv -----
// ----------------------------------------------------------------------------
// rrhr_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rrhr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rrhr_way_unit.sv -----
// ----------------------------------------------------------------------------
// rrhr_way_unit: per-way arithmetic unit
// Works on the state of one way per cycle: running maximum of the
// re-reference values, aging, hit promotion and miss fill insertion.
// ----------------------------------------------------------------------------
module rrhr_way_unit
  import rrhr_pkg::*;
(
  input  way_op_e    op_i,
  input  blk_t       blk_i,
  input  logic [1:0] top_i,
  input  logic [1:0] add_i,
  output blk_t       blk_o,
  output logic [1:0] top_o,
  output logic [1:0] depth_o
);

  always_comb begin
    blk_o   = blk_i;
    top_o   = top_i;
    depth_o = 2'd0;
    unique case (op_i)
      OP_MAX: begin
        top_o = (blk_i.rrpv > top_i) ? blk_i.rrpv : top_i;
      end
      OP_AGE: begin
        // The addend never pushes a value past the set maximum of three.
        blk_o.rrpv = blk_i.rrpv + add_i;
      end
      OP_HIT: begin
        blk_o.rrpv  = 2'd0;
        blk_o.reuse = (blk_i.reuse == CTR_MAX) ? CTR_MAX : blk_i.reuse + 2'd1;
        blk_o.dead  = (blk_i.dead == CTR_MAX) ? CTR_MAX : blk_i.dead + 2'd1;
      end
      OP_FILL: begin
        if (blk_i.reuse[1] || blk_i.dead[1]) begin
          depth_o = 2'd0;
        end else if (blk_i.reuse == 2'd0 && blk_i.dead == 2'd0) begin
          depth_o = RRPV_MAX;
        end else begin
          depth_o = DEPTH_DEFAULT;
        end
        blk_o.rrpv  = depth_o;
        blk_o.reuse = CTR_FILL;
        blk_o.dead  = CTR_FILL;
      end
      default: begin
        blk_o = blk_i;
      end
    endcase
  end

endmodule
